// ===== hw/rtl/rccc_pkg.sv =====
// Shared types and constants for the regex character class compiler.
// Used by the front parser, the command queue and the word emitter.
package rccc_pkg;

	localparam int SET_BITS = 256;
	localparam int WORD_BITS = 64;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] CH_BACKSLASH = 8'd92;
	localparam logic [7:0] CH_CARET = 8'd94;
	localparam logic [7:0] CH_LBRACKET = 8'd91;
	localparam logic [7:0] CH_RBRACKET = 8'd93;
	localparam logic [7:0] CH_STAR = 8'd42;
	localparam logic [7:0] CH_PLUS = 8'd43;
	localparam logic [7:0] CH_QUESTION = 8'd63;
	localparam logic [7:0] CH_DOT = 8'd46;
	localparam logic [7:0] CH_DASH = 8'd45;
	localparam logic [7:0] CH_LOWER_N = 8'd110;
	localparam logic [7:0] CH_LOWER_T = 8'd116;
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_TAB = 8'd9;

	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_STAR = 2'd1;
	localparam logic [1:0] OP_PLUS = 2'd2;
	localparam logic [1:0] OP_QUESTION = 2'd3;

	localparam logic [2:0] ERR_OK = 3'd0;
	localparam logic [2:0] ERR_TRAILING_ESC = 3'd1;
	localparam logic [2:0] ERR_NO_CLOSE = 3'd2;
	localparam logic [2:0] ERR_LONE_OP = 3'd3;
	localparam logic [2:0] ERR_BAD_RANGE = 3'd4;
	localparam logic [2:0] ERR_DOUBLE_NEG = 3'd5;

	typedef struct packed {
		logic                is_set;
		logic [SET_BITS-1:0] bits;
		logic [1:0]          op;
		logic [2:0]          err;
		logic                done;
	} entry_t;

endpackage

// ===== hw/rtl/rccc_front.sv =====
// Front parser of the regex character class compiler: accepts pattern bytes,
// builds character sets and pushes result commands. Depends on rccc_pkg.
module rccc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pattern_valid,
	output logic                  pattern_stall,
	input  logic [7:0]            pattern_byte,
	input  logic                  pattern_end,
	output logic                  push_valid,
	output rccc_pkg::entry_t      push_data,
	input  logic                  queue_full
);

	typedef enum logic [2:0] {
		MODE_NORMAL     = 3'd0,
		MODE_ESC        = 3'd1,
		MODE_CLASS      = 3'd2,
		MODE_CLASS_ESC  = 3'd3,
		MODE_CLASS_CHAR = 3'd4,
		MODE_CLASS_DASH = 3'd5
	} mode_t;

	mode_t                           mode_q, n_mode;
	logic [rccc_pkg::SET_BITS-1:0]   bits_q, n_bits;
	logic                            gp_q, n_gp;
	logic                            pinv_q, n_pinv;
	logic                            invn_q, n_invn;
	logic [7:0]                      rs_q, n_rs;
	logic                            flush_q, n_flush;

	logic [1:0]                      op_b;
	logic [7:0]                      esc_b;
	logic [rccc_pkg::SET_BITS-1:0]   ones;
	logic [rccc_pkg::SET_BITS-1:0]   range_mask;
	logic                            fin;
	logic [2:0]                      err;
	logic                            go;
	logic                            hold_flush;

	assign ones = '1;

	always_comb begin
		unique case (pattern_byte)
			rccc_pkg::CH_STAR:     op_b = rccc_pkg::OP_STAR;
			rccc_pkg::CH_PLUS:     op_b = rccc_pkg::OP_PLUS;
			rccc_pkg::CH_QUESTION: op_b = rccc_pkg::OP_QUESTION;
			default:               op_b = rccc_pkg::OP_NONE;
		endcase
		unique case (pattern_byte)
			rccc_pkg::CH_LOWER_N: esc_b = rccc_pkg::CH_NEWLINE;
			rccc_pkg::CH_LOWER_T: esc_b = rccc_pkg::CH_TAB;
			default:              esc_b = pattern_byte;
		endcase
	end

	assign range_mask = (ones << rs_q) & (ones >> (8'd255 - pattern_byte));

	// A held set followed by a byte that starts something new goes out on its
	// own while that byte is stalled; the byte itself is taken after the push.
	assign hold_flush = !flush_q && mode_q == MODE_NORMAL && gp_q && op_b == rccc_pkg::OP_NONE
		&& !(pattern_end && pattern_byte == rccc_pkg::CH_CARET);
	assign pattern_stall = queue_full || hold_flush;
	assign go = pattern_valid && !queue_full;

	always_comb begin
		n_mode = mode_q;
		n_bits = bits_q;
		n_gp = gp_q;
		n_pinv = pinv_q;
		n_invn = invn_q;
		n_rs = rs_q;
		n_flush = flush_q;
		fin = 1'b0;
		err = rccc_pkg::ERR_OK;
		push_valid = 1'b0;
		push_data = '{is_set: 1'b0, bits: '0, op: rccc_pkg::OP_NONE,
			err: rccc_pkg::ERR_OK, done: 1'b0};

		if (go) begin
			if (flush_q) begin
				if (pattern_end) begin
					push_valid = 1'b1;
					push_data.done = 1'b1;
					n_flush = 1'b0;
				end
			end else if (mode_q == MODE_NORMAL && gp_q) begin
				push_valid = 1'b1;
				push_data.is_set = 1'b1;
				push_data.bits = bits_q;
				push_data.op = op_b;
				push_data.done = !hold_flush && pattern_end;
				n_gp = 1'b0;
				if (!hold_flush && pattern_end) begin
					n_bits = '0;
					n_pinv = 1'b0;
					n_invn = 1'b0;
					n_rs = '0;
				end
			end else begin
				unique case (mode_q) inside
					MODE_NORMAL: begin
						if (pattern_byte == rccc_pkg::CH_CARET) begin
							if (invn_q) begin
								err = rccc_pkg::ERR_DOUBLE_NEG;
							end else begin
								n_invn = 1'b1;
							end
						end else if (op_b != rccc_pkg::OP_NONE
							|| pattern_byte == rccc_pkg::CH_RBRACKET) begin
							err = rccc_pkg::ERR_LONE_OP;
						end else begin
							n_bits = '0;
							n_pinv = invn_q;
							n_invn = 1'b0;
							if (pattern_byte == rccc_pkg::CH_BACKSLASH) begin
								n_mode = MODE_ESC;
							end else if (pattern_byte == rccc_pkg::CH_LBRACKET) begin
								n_mode = MODE_CLASS;
							end else if (pattern_byte == rccc_pkg::CH_DOT) begin
								n_bits = ones;
								fin = 1'b1;
							end else begin
								n_bits[pattern_byte] = 1'b1;
								fin = 1'b1;
							end
						end
					end
					MODE_ESC: begin
						n_bits[esc_b] = 1'b1;
						fin = 1'b1;
					end
					MODE_CLASS_ESC: begin
						n_bits[esc_b] = 1'b1;
						n_mode = MODE_CLASS;
					end
					MODE_CLASS, MODE_CLASS_CHAR: begin
						if (mode_q == MODE_CLASS_CHAR && pattern_byte == rccc_pkg::CH_DASH) begin
							n_mode = MODE_CLASS_DASH;
						end else begin
							if (mode_q == MODE_CLASS_CHAR) begin
								n_bits[rs_q] = 1'b1;
							end
							if (pattern_byte == rccc_pkg::CH_RBRACKET) begin
								fin = 1'b1;
							end else if (pattern_byte == rccc_pkg::CH_BACKSLASH) begin
								n_mode = MODE_CLASS_ESC;
							end else begin
								n_rs = pattern_byte;
								n_mode = MODE_CLASS_CHAR;
							end
						end
					end
					MODE_CLASS_DASH: begin
						if (pattern_byte == rccc_pkg::CH_RBRACKET) begin
							n_bits[rs_q] = 1'b1;
							n_bits[rccc_pkg::CH_DASH] = 1'b1;
							fin = 1'b1;
						end else if (rs_q > pattern_byte) begin
							err = rccc_pkg::ERR_BAD_RANGE;
						end else begin
							n_bits = n_bits | range_mask;
							n_mode = MODE_CLASS;
						end
					end
					default: begin
						n_mode = MODE_NORMAL;
					end
				endcase

				if (fin) begin
					n_bits = n_pinv ? ~n_bits : n_bits;
					n_pinv = 1'b0;
					n_gp = 1'b1;
					n_mode = MODE_NORMAL;
				end

				if (err == rccc_pkg::ERR_OK && pattern_end) begin
					if (n_mode == MODE_ESC) begin
						err = rccc_pkg::ERR_TRAILING_ESC;
					end else if (n_mode != MODE_NORMAL) begin
						err = rccc_pkg::ERR_NO_CLOSE;
					end
				end

				if (err != rccc_pkg::ERR_OK) begin
					push_valid = 1'b1;
					push_data.err = err;
					push_data.done = pattern_end;
					n_flush = !pattern_end;
				end else if (pattern_end) begin
					push_valid = 1'b1;
					push_data.is_set = n_gp;
					push_data.bits = n_gp ? n_bits : '0;
					push_data.done = 1'b1;
				end

				if (err != rccc_pkg::ERR_OK || pattern_end) begin
					n_mode = MODE_NORMAL;
					n_bits = '0;
					n_gp = 1'b0;
					n_pinv = 1'b0;
					n_invn = 1'b0;
					n_rs = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			bits_q <= '0;
			gp_q <= 1'b0;
			pinv_q <= 1'b0;
			invn_q <= 1'b0;
			rs_q <= '0;
			flush_q <= 1'b0;
		end else begin
			mode_q <= n_mode;
			bits_q <= n_bits;
			gp_q <= n_gp;
			pinv_q <= n_pinv;
			invn_q <= n_invn;
			rs_q <= n_rs;
			flush_q <= n_flush;
		end
	end

	a_flush_idle: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> (mode_q == MODE_NORMAL && !gp_q && !invn_q))
		else $error("front: dropping input with parse state live");
	a_held_normal: assert property (@(posedge clk) disable iff (!arst_n)
		gp_q |-> (mode_q == MODE_NORMAL && !pinv_q && !invn_q))
		else $error("front: held set outside normal mode");
	a_hold_flush_push: assert property (@(posedge clk) disable iff (!arst_n)
		(pattern_valid && !queue_full && hold_flush) |=> !gp_q)
		else $error("front: held set not released after push");

endmodule

// ===== hw/rtl/rccc_queue.sv =====
// Two-entry command queue between the front parser and the word emitter.
// Depends on rccc_pkg for the entry type.
module rccc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	input  rccc_pkg::entry_t push_data,
	output logic             full,
	output logic             pop_valid,
	input  logic             pop,
	output rccc_pkg::entry_t pop_data
);

	localparam int PW = $clog2(rccc_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(rccc_pkg::QUEUE_DEPTH + 1);

	rccc_pkg::entry_t mem_q [rccc_pkg::QUEUE_DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full = cnt_q == CW'(rccc_pkg::QUEUE_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign do_push = push_valid && !full;
	assign do_pop = pop && pop_valid;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(rccc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(rccc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(rccc_pkg::QUEUE_DEPTH))
		else $error("queue: occupancy beyond depth");
	a_no_lost_push: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue: push not counted");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push && cnt_q == CW'(1)) |=> !pop_valid)
		else $error("queue: valid after last entry left");

endmodule

// ===== hw/rtl/rccc_back.sv =====
// Word emitter of the regex character class compiler: takes queued commands
// and sends each as one result or four 64-bit set words. Depends on rccc_pkg.
module rccc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  rccc_pkg::entry_t cmd_data,
	output logic             cmd_pop,
	output logic             result_valid,
	input  logic             result_stall,
	output logic [63:0]      set_word,
	output logic [1:0]       word_index,
	output logic [1:0]       repeat_op,
	output logic             last_word,
	output logic             pattern_done,
	output logic [2:0]       error_code
);

	rccc_pkg::entry_t ent_q;
	logic             busy_q;
	logic [1:0]       cnt_q;
	logic             xfer;
	logic             load;

	assign result_valid = busy_q;
	assign set_word = ent_q.bits[cnt_q * rccc_pkg::WORD_BITS +: rccc_pkg::WORD_BITS];
	assign word_index = cnt_q;
	assign repeat_op = ent_q.op;
	assign last_word = !ent_q.is_set || cnt_q == 2'd3;
	assign pattern_done = ent_q.done && last_word;
	assign error_code = ent_q.err;

	assign xfer = busy_q && !result_stall;
	assign load = cmd_valid && (!busy_q || (xfer && last_word));
	assign cmd_pop = load;

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= cmd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (xfer) begin
			if (last_word) begin
				busy_q <= 1'b0;
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	a_word_step: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && !last_word) |=> (result_valid && word_index == $past(word_index) + 1'b1
			&& repeat_op == $past(repeat_op)))
		else $error("back: set words out of order");
	a_single_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !ent_q.is_set) |-> (set_word == '0 && word_index == '0))
		else $error("back: single result carries set data");
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && error_code != rccc_pkg::ERR_OK) |-> (last_word && word_index == '0))
		else $error("back: error result not a single word");

endmodule

// ===== hw/rtl/regex_char_class_compiler.sv =====
// Top level of the regex character class compiler.
// Instantiates rccc_front, rccc_queue and rccc_back; depends on rccc_pkg.
//
// A byte that is not a repeat operator and follows a finished set is stalled
// while that set is pushed to the two-entry command queue, unless it is a
// caret that ends the pattern. Each character set leaves as four 64-bit
// words, one per cycle while result_stall is low, and every error or end
// marker as a single word, so the back end's one word per cycle sets the
// throughput; one byte can release up to two sets. The front keeps
// accepting bytes while the queue has room.
module regex_char_class_compiler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pattern_valid,
	output logic        pattern_stall,
	input  logic [7:0]  pattern_byte,
	input  logic        pattern_end,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [63:0] set_word,
	output logic [1:0]  word_index,
	output logic [1:0]  repeat_op,
	output logic        last_word,
	output logic        pattern_done,
	output logic [2:0]  error_code
);

	logic             push_valid;
	rccc_pkg::entry_t push_data;
	logic             queue_full;
	logic             cmd_valid;
	logic             cmd_pop;
	rccc_pkg::entry_t cmd_data;

	rccc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.pattern_valid (pattern_valid),
		.pattern_stall (pattern_stall),
		.pattern_byte  (pattern_byte),
		.pattern_end   (pattern_end),
		.push_valid    (push_valid),
		.push_data     (push_data),
		.queue_full    (queue_full)
	);

	rccc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.full       (queue_full),
		.pop_valid  (cmd_valid),
		.pop        (cmd_pop),
		.pop_data   (cmd_data)
	);

	rccc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_data     (cmd_data),
		.cmd_pop      (cmd_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.set_word     (set_word),
		.word_index   (word_index),
		.repeat_op    (repeat_op),
		.last_word    (last_word),
		.pattern_done (pattern_done),
		.error_code   (error_code)
	);

endmodule

// ===== sim/regex_char_class_compiler_test.sv =====
// Self-checking testbench for regex_char_class_compiler: pattern bytes go in, character sets
// and error words come out and are compared against a built-in parser model.
// Depends on rccc_pkg and the RTL under hw/rtl; runs a directed script, then random patterns.
module regex_char_class_compiler_test;

	typedef enum logic [2:0] {
		PM_NORMAL, PM_ESC, PM_CLASS, PM_CLASS_ESC, PM_CLASS_CHAR, PM_CLASS_DASH
	} parse_mode_t;

	typedef struct packed {
		logic [63:0] bits;
		logic [1:0]  idx;
		logic [1:0]  op;
		logic        last;
		logic        done;
		logic [2:0]  err;
	} out_word_t;

	typedef struct packed {
		logic [7:0] b;
		logic       e;
		logic       typed;
		logic [2:0] err;
	} script_row_t;

	localparam int SCRIPT_LEN = 29;
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		{8'h00, 1'b0, 1'b0, rccc_pkg::ERR_OK},
		{rccc_pkg::CH_STAR, 1'b0, 1'b0, rccc_pkg::ERR_OK},
		{rccc_pkg::CH_PLUS, 1'b0, 1'b1, rccc_pkg::ERR_LONE_OP},
		{8'h7f, 1'b1, 1'b1, rccc_pkg::ERR_OK},
		{rccc_pkg::CH_DOT, 1'b0, 1'b0, rccc_pkg::ERR_OK},
		{rccc_pkg::CH_QUESTION, 1'b1, 1'b0, rccc_pkg::ERR_OK},
		{rccc_pkg::CH_CARET, 1'b0, 1'b0, rccc_pkg::ERR_OK},
		{rccc_pkg::CH_CARET, 1'b1, 1'b1, rccc_pkg::ERR_DOUBLE_NEG},
		{rccc_pkg::CH_LBRACKET, 1'b0, 1'b0, rccc_pkg::ERR_OK},
		{8'h7a, 1'b0, 1'b0, rccc_pkg::ERR_OK},
		{rccc_pkg::CH_DASH, 1'b0, 1'b0, rccc_pkg::ERR_OK},
		{8'h61, 1'b0, 1'b1, rccc_pkg::ERR_BAD_RANGE},
		{rccc_pkg::CH_RBRACKET, 1'b1, 1'b1, rccc_pkg::ERR_OK},
		{rccc_pkg::CH_BACKSLASH, 1'b1, 1'b1, rccc_pkg::ERR_TRAILING_ESC},
		{rccc_pkg::CH_CARET, 1'b0, 1'b0, rccc_pkg::ERR_OK},
		{rccc_pkg::CH_LBRACKET, 1'b0, 1'b0, rccc_pkg::ERR_OK},
		{rccc_pkg::CH_RBRACKET, 1'b0, 1'b0, rccc_pkg::ERR_OK},
		{rccc_pkg::CH_PLUS, 1'b0, 1'b0, rccc_pkg::ERR_OK},
		{rccc_pkg::CH_LBRACKET, 1'b0, 1'b0, rccc_pkg::ERR_OK},
		{rccc_pkg::CH_BACKSLASH, 1'b0, 1'b0, rccc_pkg::ERR_OK},
		{rccc_pkg::CH_RBRACKET, 1'b0, 1'b0, rccc_pkg::ERR_OK},
		{8'h61, 1'b0, 1'b0, rccc_pkg::ERR_OK},
		{rccc_pkg::CH_DASH, 1'b0, 1'b0, rccc_pkg::ERR_OK},
		{rccc_pkg::CH_RBRACKET, 1'b0, 1'b0, rccc_pkg::ERR_OK},
		{rccc_pkg::CH_BACKSLASH, 1'b0, 1'b0, rccc_pkg::ERR_OK},
		{rccc_pkg::CH_LOWER_T, 1'b0, 1'b0, rccc_pkg::ERR_OK},
		{rccc_pkg::CH_RBRACKET, 1'b0, 1'b0, rccc_pkg::ERR_OK},
		{8'h71, 1'b1, 1'b1, rccc_pkg::ERR_OK},
		{8'hff, 1'b1, 1'b0, rccc_pkg::ERR_OK}
	};

	logic        clk;
	logic        arst_n;
	logic        pattern_valid;
	logic        pattern_stall;
	logic [7:0]  pattern_byte;
	logic        pattern_end;
	logic        result_valid;
	logic        result_stall;
	logic [63:0] set_word;
	logic [1:0]  word_index;
	logic [1:0]  repeat_op;
	logic        last_word;
	logic        pattern_done;
	logic [2:0]  error_code;

	logic [63:0] cls [4];
	parse_mode_t mode;
	logic        grp;
	logic        pinv;
	logic        inext;
	logic [7:0]  rstart;
	logic        flush;

	out_word_t   step_words [$];
	out_word_t   pending_words [$];
	logic [7:0]  pat_bytes [$];
	out_word_t   want;
	out_word_t   got;
	logic        item_typed;
	logic [2:0]  item_err;
	logic        sender_calm;
	logic        recv_calm;
	int          stall_left;
	int          mismatches;
	int          items_sent;
	int          words_seen;
	int          patterns_closed;
	int          errors_seen;

	regex_char_class_compiler uut (
		.clk(clk),
		.arst_n(arst_n),
		.pattern_valid(pattern_valid),
		.pattern_stall(pattern_stall),
		.pattern_byte(pattern_byte),
		.pattern_end(pattern_end),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.set_word(set_word),
		.word_index(word_index),
		.repeat_op(repeat_op),
		.last_word(last_word),
		.pattern_done(pattern_done),
		.error_code(error_code)
	);

	function automatic void clear_state();
		for (int i = 0; i < 4; i++) cls[i] = '0;
		mode = PM_NORMAL;
		grp = 1'b0;
		pinv = 1'b0;
		inext = 1'b0;
		rstart = '0;
		flush = 1'b0;
	endfunction

	function automatic void push_word(input logic [63:0] w, input logic [1:0] i,
			input logic [1:0] op, input logic last, input logic [2:0] err);
		out_word_t r;
		r = {w, i, op, last, 1'b0, err};
		step_words.push_back(r);
	endfunction

	function automatic void mark_done();
		out_word_t r;
		r = step_words[step_words.size() - 1];
		r.done = 1'b1;
		step_words[step_words.size() - 1] = r;
	endfunction

	function automatic void push_set(input logic [1:0] op);
		for (int i = 0; i < 4; i++) push_word(cls[i], 2'(i), op, i == 3, rccc_pkg::ERR_OK);
	endfunction

	function automatic void add_member(input logic [7:0] v);
		cls[v[7:6]][v[5:0]] = 1'b1;
	endfunction

	function automatic void begin_atom();
		for (int i = 0; i < 4; i++) cls[i] = '0;
		pinv = inext;
		inext = 1'b0;
	endfunction

	function automatic void finish_atom();
		if (pinv) begin
			for (int i = 0; i < 4; i++) cls[i] = ~cls[i];
		end
		pinv = 1'b0;
		grp = 1'b1;
		mode = PM_NORMAL;
	endfunction

	function automatic logic [1:0] op_of(input logic [7:0] b);
		case (b)
			rccc_pkg::CH_STAR: return rccc_pkg::OP_STAR;
			rccc_pkg::CH_PLUS: return rccc_pkg::OP_PLUS;
			rccc_pkg::CH_QUESTION: return rccc_pkg::OP_QUESTION;
			default: return rccc_pkg::OP_NONE;
		endcase
	endfunction

	function automatic logic [7:0] esc_value(input logic [7:0] b);
		if (b == rccc_pkg::CH_LOWER_N) return rccc_pkg::CH_NEWLINE;
		if (b == rccc_pkg::CH_LOWER_T) return rccc_pkg::CH_TAB;
		return b;
	endfunction

	function automatic void class_entry(input logic [7:0] b);
		if (b == rccc_pkg::CH_RBRACKET) begin
			finish_atom();
		end else if (b == rccc_pkg::CH_BACKSLASH) begin
			mode = PM_CLASS_ESC;
		end else begin
			rstart = b;
			mode = PM_CLASS_CHAR;
		end
	endfunction

	function automatic logic [2:0] normal_entry(input logic [7:0] b);
		if (b == rccc_pkg::CH_BACKSLASH) begin
			begin_atom();
			mode = PM_ESC;
		end else if (b == rccc_pkg::CH_CARET) begin
			if (inext) return rccc_pkg::ERR_DOUBLE_NEG;
			inext = 1'b1;
		end else if (b == rccc_pkg::CH_LBRACKET) begin
			begin_atom();
			mode = PM_CLASS;
		end else if (op_of(b) != rccc_pkg::OP_NONE || b == rccc_pkg::CH_RBRACKET) begin
			return rccc_pkg::ERR_LONE_OP;
		end else if (b == rccc_pkg::CH_DOT) begin
			begin_atom();
			for (int i = 0; i < 4; i++) cls[i] = '1;
			finish_atom();
		end else begin
			begin_atom();
			add_member(b);
			finish_atom();
		end
		return rccc_pkg::ERR_OK;
	endfunction

	// Fills step_words with the words that one pattern byte releases.
	function automatic void compile_byte(input logic [7:0] b, input logic e);
		logic [2:0] err;
		err = rccc_pkg::ERR_OK;
		step_words.delete();
		if (flush) begin
			if (e) begin
				push_word('0, 2'd0, rccc_pkg::OP_NONE, 1'b1, rccc_pkg::ERR_OK);
				mark_done();
				clear_state();
			end
			return;
		end
		case (mode)
			PM_NORMAL: begin
				if (grp && op_of(b) != rccc_pkg::OP_NONE) begin
					push_set(op_of(b));
					grp = 1'b0;
				end else begin
					if (grp) begin
						push_set(rccc_pkg::OP_NONE);
						grp = 1'b0;
					end
					err = normal_entry(b);
				end
			end
			PM_ESC: begin
				add_member(esc_value(b));
				finish_atom();
			end
			PM_CLASS: class_entry(b);
			PM_CLASS_ESC: begin
				add_member(esc_value(b));
				mode = PM_CLASS;
			end
			PM_CLASS_CHAR: begin
				if (b == rccc_pkg::CH_DASH) begin
					mode = PM_CLASS_DASH;
				end else begin
					add_member(rstart);
					class_entry(b);
				end
			end
			PM_CLASS_DASH: begin
				if (b == rccc_pkg::CH_RBRACKET) begin
					add_member(rstart);
					add_member(rccc_pkg::CH_DASH);
					finish_atom();
				end else if (rstart > b) begin
					err = rccc_pkg::ERR_BAD_RANGE;
				end else begin
					for (int k = int'(rstart); k <= int'(b); k++) add_member(8'(k));
					mode = PM_CLASS;
				end
			end
			default: mode = PM_NORMAL;
		endcase
		if (err == rccc_pkg::ERR_OK && e) begin
			if (mode == PM_ESC) err = rccc_pkg::ERR_TRAILING_ESC;
			else if (mode != PM_NORMAL) err = rccc_pkg::ERR_NO_CLOSE;
		end
		if (err != rccc_pkg::ERR_OK) begin
			clear_state();
			push_word('0, 2'd0, rccc_pkg::OP_NONE, 1'b1, err);
			if (e) mark_done();
			else flush = 1'b1;
			return;
		end
		if (e) begin
			if (grp) push_set(rccc_pkg::OP_NONE);
			if (step_words.size() == 0)
				push_word('0, 2'd0, rccc_pkg::OP_NONE, 1'b1, rccc_pkg::ERR_OK);
			mark_done();
			clear_state();
		end
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do begin
			b = 8'($urandom_range(0, 255));
		end while (b == rccc_pkg::CH_BACKSLASH || b == rccc_pkg::CH_CARET ||
			b == rccc_pkg::CH_LBRACKET || b == rccc_pkg::CH_RBRACKET ||
			op_of(b) != rccc_pkg::OP_NONE);
		return b;
	endfunction

	function automatic logic [7:0] class_byte();
		logic [7:0] b;
		do begin
			b = 8'($urandom_range(0, 255));
		end while (b == rccc_pkg::CH_BACKSLASH || b == rccc_pkg::CH_RBRACKET);
		return b;
	endfunction

	function automatic logic [7:0] pick_esc();
		case ($urandom_range(0, 2))
			0: return rccc_pkg::CH_LOWER_N;
			1: return rccc_pkg::CH_LOWER_T;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void build_pattern();
		int atoms;
		int items;
		int kind;
		logic closed;
		logic [7:0] lo;
		pat_bytes.delete();
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			atoms = $urandom_range(1, 6);
			for (int i = 0; i < atoms; i++) pat_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		atoms = $urandom_range(1, 5);
		for (int a = 0; a < atoms; a++) begin
			if ($urandom_range(0, 5) == 0) pat_bytes.push_back(rccc_pkg::CH_CARET);
			case ($urandom_range(0, 9)) inside
				[0:3]: pat_bytes.push_back(plain_byte());
				[4:5]: begin
					pat_bytes.push_back(rccc_pkg::CH_BACKSLASH);
					pat_bytes.push_back(pick_esc());
				end
				6: pat_bytes.push_back(rccc_pkg::CH_DOT);
				default: begin
					pat_bytes.push_back(rccc_pkg::CH_LBRACKET);
					items = $urandom_range(0, 3);
					closed = 1'b0;
					for (int j = 0; j < items && !closed; j++) begin
						lo = class_byte();
						case ($urandom_range(0, 4)) inside
							[0:1]: pat_bytes.push_back(lo);
							2: begin
								pat_bytes.push_back(lo);
								pat_bytes.push_back(rccc_pkg::CH_DASH);
								pat_bytes.push_back(8'($urandom_range(int'(lo), 255)));
							end
							3: begin
								pat_bytes.push_back(rccc_pkg::CH_BACKSLASH);
								pat_bytes.push_back(pick_esc());
							end
							default: begin
								pat_bytes.push_back(lo);
								pat_bytes.push_back(rccc_pkg::CH_DASH);
								pat_bytes.push_back(rccc_pkg::CH_RBRACKET);
								closed = 1'b1;
							end
						endcase
					end
					if (!closed) pat_bytes.push_back(rccc_pkg::CH_RBRACKET);
				end
			endcase
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 2))
					0: pat_bytes.push_back(rccc_pkg::CH_STAR);
					1: pat_bytes.push_back(rccc_pkg::CH_PLUS);
					default: pat_bytes.push_back(rccc_pkg::CH_QUESTION);
				endcase
			end
		end
		if (kind == 1 && pat_bytes.size() > 1) begin
			void'(pat_bytes.pop_back());
		end else if (kind == 2) begin
			pat_bytes.insert($urandom_range(0, pat_bytes.size() - 1),
				8'($urandom_range(0, 255)));
		end else if (kind == 3) begin
			pat_bytes.push_back(rccc_pkg::CH_CARET);
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic e, input logic typed,
			input logic [2:0] err);
		int gap;
		gap = (!sender_calm && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			pattern_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pattern_valid <= 1'b1;
		pattern_byte <= b;
		pattern_end <= e;
		item_typed <= typed;
		item_err <= err;
		@(posedge clk);
		while (pattern_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic note_mismatch(input string why, input out_word_t exp_w,
			input out_word_t act_w);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%s: expected set %h idx %0d op %0d last %0b done %0b err %0d", why,
				exp_w.bits, exp_w.idx, exp_w.op, exp_w.last, exp_w.done, exp_w.err);
			$display("    got set %h idx %0d op %0d last %0b done %0b err %0d",
				act_w.bits, act_w.idx, act_w.op, act_w.last, act_w.done, act_w.err);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10000000;
		$display("Mismatches found");
		$finish;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			recv_calm <= 1'b0;
			stall_left <= 0;
			result_stall <= 1'b0;
		end else begin
			if ($urandom_range(0, 299) == 0) recv_calm <= !recv_calm;
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				result_stall <= 1'b1;
			end else if (!recv_calm && $urandom_range(0, 3) == 0) begin
				stall_left <= pick_gap() - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Model update comes before the result check so a same-cycle result is still covered.
	always @(posedge clk) begin
		if (arst_n && pattern_valid && !pattern_stall) begin
			compile_byte(pattern_byte, pattern_end);
			if (item_typed) begin
				step_words.delete();
				push_word('0, 2'd0, rccc_pkg::OP_NONE, 1'b1, item_err);
				if (pattern_end) mark_done();
			end
			foreach (step_words[i]) pending_words.push_back(step_words[i]);
		end
		if (arst_n && result_valid && !result_stall) begin
			got = {set_word, word_index, repeat_op, last_word, pattern_done, error_code};
			words_seen++;
			if (got.done) patterns_closed++;
			if (got.err != rccc_pkg::ERR_OK) errors_seen++;
			if (pending_words.size() == 0) begin
				note_mismatch("Unexpected transfer", '0, got);
			end else begin
				want = pending_words.pop_front();
				if (got !== want) note_mismatch("Wrong transfer", want, got);
			end
		end
	end

	initial begin
		clear_state();
		arst_n <= 1'b0;
		pattern_valid <= 1'b0;
		pattern_byte <= '0;
		pattern_end <= 1'b0;
		item_typed <= 1'b0;
		item_err <= rccc_pkg::ERR_OK;
		sender_calm = 1'b0;
		mismatches = 0;
		items_sent = 0;
		words_seen = 0;
		patterns_closed = 0;
		errors_seen = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < SCRIPT_LEN; i++)
			send_byte(SCRIPT[i].b, SCRIPT[i].e, SCRIPT[i].typed, SCRIPT[i].err);
		pattern_valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);

		while (items_sent < 210) begin
			if ($urandom_range(0, 7) == 0) sender_calm = !sender_calm;
			build_pattern();
			foreach (pat_bytes[i])
				send_byte(pat_bytes[i], i == pat_bytes.size() - 1, 1'b0, rccc_pkg::ERR_OK);
		end
		pattern_valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);

		$display("Sent %0d pattern bytes; checked %0d result words over %0d patterns,",
			items_sent, words_seen, patterns_closed);
		$display("%0d of them error words; %0d mismatching transfers.", errors_seen, mismatches);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

// ===== regex_char_class_compiler.f =====
hw/rtl/rccc_pkg.sv
hw/rtl/rccc_front.sv
hw/rtl/rccc_queue.sv
hw/rtl/rccc_back.sv
hw/rtl/regex_char_class_compiler.sv
sim/regex_char_class_compiler_test.sv
